// File: src/ipf_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipf_pkg
// Shared constants, types and helpers of the incremental PID core.
// ---------------------------------------------------------------------------
package ipf_pkg;

   localparam int FRAC_BITS  = 16;
   localparam bit WRAP_ANGLE = 1'b0;

   localparam int DATA_W    = 32;
   localparam int PERIOD_W  = 24;
   localparam int CSR_IDX_W = 3;

   localparam longint PI_FIX =
      (64'sd3373259426 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
   localparam longint TWO_PI = 2 * PI_FIX;

   localparam int DVSR_W = 28;
   localparam int DVND_W = DATA_W + 2 + FRAC_BITS;
   localparam int CNT_W  = $clog2(DVND_W + 1);
   localparam int OPND_W = DATA_W + 1;
   localparam int PROD_W = 2 * OPND_W;
   localparam int TERM_W = PROD_W - FRAC_BITS;
   localparam int ACC_W  = TERM_W + 3;
   localparam int INC_W  = DATA_W + PERIOD_W + 2 - FRAC_BITS;
   localparam int SAT_W  = 64;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P, CSR_GAIN_I, CSR_GAIN_D, CSR_GAIN_FF_LIN,
      CSR_GAIN_FF_SQ, CSR_GAIN_FF_ACC, CSR_DRIVE_MIN, CSR_DRIVE_MAX
   } csr_index_type;

   typedef enum logic [2:0] {
      DIV_WRAP, DIV_ERR, DIV_RATE, DIV_RERR, DIV_ACCEL
   } div_sel_type;

   typedef enum logic [3:0] {
      MUL_NONE, MUL_SQ, MUL_I, MUL_P, MUL_D, MUL_ACC, MUL_LIN, MUL_FFSQ, MUL_INC
   } mul_op_type;

   typedef struct packed {
      logic        load;
      logic        prep;
      logic        div_start;
      div_sel_type div_sel;
      mul_op_type  mul_op;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic first;
      logic out_busy;
   } sts_type;

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SAT_W-1:0] x);
      logic [SAT_W-DATA_W:0] top;
      top = x[SAT_W-1:DATA_W-1];
      if (top == '0 || top == '1) begin
         return x[DATA_W-1:0];
      end
      return x[SAT_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
   endfunction

endpackage

// File: src/ipf_if.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipf_req_if / ipf_rsp_if
// Valid/ready channels carrying requests and drive results.
// ---------------------------------------------------------------------------
interface ipf_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [ipf_pkg::DATA_W-1:0]       measured;
   logic signed [ipf_pkg::DATA_W-1:0]       target;
   logic signed [ipf_pkg::DATA_W-1:0]       measured_rate;
   logic signed [ipf_pkg::DATA_W-1:0]       target_rate;
   logic signed [ipf_pkg::DATA_W-1:0]       target_accel;
   logic        [ipf_pkg::PERIOD_W-1:0]     period;

   modport source (output valid, measured, target, measured_rate, target_rate,
                   target_accel, period, input ready);
   modport sink   (input valid, measured, target, measured_rate, target_rate,
                   target_accel, period, output ready);
endinterface

interface ipf_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [ipf_pkg::DATA_W-1:0] drive;

   modport source (output valid, drive, input ready);
   modport sink   (input valid, drive, output ready);
endinterface

// File: src/ipf_div.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipf_div
// Restoring divider, one quotient bit per cycle, truncating signed result.
// ---------------------------------------------------------------------------
module ipf_div (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic signed [ipf_pkg::DVND_W-1:0]     dividend,
   input  logic        [ipf_pkg::DVSR_W-1:0]     divisor,
   output logic                                  done,
   output logic signed [ipf_pkg::DVND_W:0]       quotient,
   output logic signed [ipf_pkg::DVSR_W:0]       remainder
);
   localparam int MAG_W = ipf_pkg::DVND_W;
   localparam int DV_W  = ipf_pkg::DVSR_W;

   logic [MAG_W-1:0]           quo_ff, quo_in;
   logic [DV_W-1:0]            rem_ff, rem_in;
   logic [DV_W-1:0]            dvsr_ff;
   logic                       neg_ff;
   logic [ipf_pkg::CNT_W-1:0]  cnt_ff;
   logic                       done_ff;
   logic [DV_W:0]              rem_sh, rem_diff;
   logic                       ge;

   always_comb begin
      rem_sh   = {rem_ff, quo_ff[MAG_W-1]};
      rem_diff = rem_sh - {1'b0, dvsr_ff};
      ge       = rem_sh >= {1'b0, dvsr_ff};
      rem_in   = ge ? rem_diff[DV_W-1:0] : rem_sh[DV_W-1:0];
      quo_in   = {quo_ff[MAG_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else if (start) begin
         cnt_ff  <= ipf_pkg::CNT_W'(MAG_W);
         done_ff <= 1'b0;
      end else begin
         done_ff <= (cnt_ff == ipf_pkg::CNT_W'(1));
         if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         neg_ff  <= dividend[MAG_W-1];
         quo_ff  <= dividend[MAG_W-1] ? (~dividend + 1'b1) : dividend;
         rem_ff  <= '0;
         dvsr_ff <= divisor;
      end else if (cnt_ff != '0) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});
   assign remainder = neg_ff ? -$signed({1'b0, rem_ff}) : $signed({1'b0, rem_ff});

endmodule

// File: src/ipf_dp.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipf_dp
// Datapath: request and state registers, shared divider and multiplier,
// accumulator, clamp and result register.
// ---------------------------------------------------------------------------
module ipf_dp (
   input  logic                                    clock,
   input  logic                                    reset,
   input  ipf_pkg::cmd_type                        cmd,
   output ipf_pkg::sts_type                        sts,
   input  logic                                    csr_we,
   input  logic        [ipf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic        [ipf_pkg::DATA_W-1:0]       csr_wdata,
   input  logic signed [ipf_pkg::DATA_W-1:0]       req_measured,
   input  logic signed [ipf_pkg::DATA_W-1:0]       req_target,
   input  logic signed [ipf_pkg::DATA_W-1:0]       req_measured_rate,
   input  logic signed [ipf_pkg::DATA_W-1:0]       req_target_rate,
   input  logic signed [ipf_pkg::DATA_W-1:0]       req_target_accel,
   input  logic        [ipf_pkg::PERIOD_W-1:0]     req_period,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [ipf_pkg::DATA_W-1:0]       rsp_drive
);
   localparam int W  = ipf_pkg::DATA_W;
   localparam int DW = ipf_pkg::DVND_W;
   localparam int VW = ipf_pkg::DVSR_W;
   localparam int OW = ipf_pkg::OPND_W;

   logic signed [W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic signed [W-1:0] gain_ff_lin_ff, gain_ff_sq_ff, gain_ff_acc_ff;
   logic signed [W-1:0] drive_min_ff, drive_max_ff;

   logic signed [W-1:0] meas_ff, targ_ff, mrate_ff, trate_ff, tacc_ff;
   logic [ipf_pkg::PERIOD_W-1:0] per_ff;

   logic signed [W-1:0] last_error_ff, last_rate_ff, last_rate_error_ff;
   logic signed [W-1:0] last_accel_ff, last_drive_ff;
   logic                first_ff;

   logic signed [W-1:0] err_ff, rerr_ff, qe_ff, qv_ff, qr_ff, qa_ff, sq_ff;
   logic signed [ipf_pkg::ACC_W-1:0] acc_ff;
   logic signed [ipf_pkg::INC_W-1:0] inc_ff;
   logic signed [ipf_pkg::PROD_W-1:0] prod_ff;
   ipf_pkg::mul_op_type wb_ff;

   logic                rsp_valid_ff;
   logic signed [W-1:0] rsp_drive_ff;

   logic signed [W:0]   err_raw, diff;
   logic signed [DW-1:0] dividend;
   logic [VW-1:0]       divisor;
   logic [VW-1:0]       per_eff;
   logic                div_done;
   logic signed [DW:0]  div_quo;
   logic signed [VW:0]  div_rem;
   logic signed [W+1:0] wrap_err;
   logic signed [W-1:0] quo_sat;
   logic signed [OW-1:0] opnd_a, opnd_b, qv_abs;
   logic signed [ipf_pkg::TERM_W-1:0] term;
   logic signed [W-1:0] sum_sat;
   logic signed [ipf_pkg::INC_W:0] drv_sum;
   logic signed [W-1:0] drv;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff      <= '0;
         gain_i_ff      <= '0;
         gain_d_ff      <= '0;
         gain_ff_lin_ff <= '0;
         gain_ff_sq_ff  <= '0;
         gain_ff_acc_ff <= '0;
         drive_min_ff   <= {1'b1, {(W-1){1'b0}}};
         drive_max_ff   <= {1'b0, {(W-1){1'b1}}};
      end else if (csr_we) begin
         case (ipf_pkg::csr_index_type'(csr_index))
            ipf_pkg::CSR_GAIN_P:      gain_p_ff      <= csr_wdata;
            ipf_pkg::CSR_GAIN_I:      gain_i_ff      <= csr_wdata;
            ipf_pkg::CSR_GAIN_D:      gain_d_ff      <= csr_wdata;
            ipf_pkg::CSR_GAIN_FF_LIN: gain_ff_lin_ff <= csr_wdata;
            ipf_pkg::CSR_GAIN_FF_SQ:  gain_ff_sq_ff  <= csr_wdata;
            ipf_pkg::CSR_GAIN_FF_ACC: gain_ff_acc_ff <= csr_wdata;
            ipf_pkg::CSR_DRIVE_MIN:   drive_min_ff   <= csr_wdata;
            ipf_pkg::CSR_DRIVE_MAX:   drive_max_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      err_raw = (W+1)'(meas_ff) - (W+1)'(targ_ff);
      per_eff = (per_ff == '0) ? VW'(1) : VW'(per_ff);
      case (cmd.div_sel)
         ipf_pkg::DIV_ERR:   diff = (W+1)'(err_ff) - (W+1)'(last_error_ff);
         ipf_pkg::DIV_RATE:  diff = (W+1)'(mrate_ff) - (W+1)'(last_rate_ff);
         ipf_pkg::DIV_RERR:  diff = (W+1)'(rerr_ff) - (W+1)'(last_rate_error_ff);
         ipf_pkg::DIV_ACCEL: diff = (W+1)'(tacc_ff) - (W+1)'(last_accel_ff);
         default:            diff = '0;
      endcase
      if (cmd.div_sel == ipf_pkg::DIV_WRAP) begin
         dividend = DW'(err_raw) + DW'(ipf_pkg::PI_FIX);
         divisor  = VW'(ipf_pkg::TWO_PI);
      end else begin
         dividend = DW'(diff) <<< ipf_pkg::FRAC_BITS;
         divisor  = per_eff;
      end
      wrap_err = (W+2)'(div_rem) - (W+2)'(ipf_pkg::PI_FIX)
               + (div_rem[VW] ? (W+2)'(ipf_pkg::TWO_PI) : '0);
      quo_sat  = ipf_pkg::sat32(ipf_pkg::SAT_W'(div_quo));
   end

   ipf_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (dividend),
      .divisor   (divisor),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   always_comb begin
      qv_abs  = qv_ff[W-1] ? -OW'(qv_ff) : OW'(qv_ff);
      sum_sat = ipf_pkg::sat32(ipf_pkg::SAT_W'(acc_ff));
      case (cmd.mul_op)
         ipf_pkg::MUL_SQ:   begin opnd_a = OW'(qv_ff);          opnd_b = qv_abs;         end
         ipf_pkg::MUL_I:    begin opnd_a = OW'(gain_i_ff);      opnd_b = OW'(err_ff);    end
         ipf_pkg::MUL_P:    begin opnd_a = OW'(gain_p_ff);      opnd_b = OW'(qe_ff);     end
         ipf_pkg::MUL_D:    begin opnd_a = OW'(gain_d_ff);      opnd_b = OW'(qr_ff);     end
         ipf_pkg::MUL_ACC:  begin opnd_a = OW'(gain_ff_acc_ff); opnd_b = OW'(qa_ff);     end
         ipf_pkg::MUL_LIN:  begin opnd_a = OW'(gain_ff_lin_ff); opnd_b = OW'(qv_ff);     end
         ipf_pkg::MUL_FFSQ: begin opnd_a = OW'(gain_ff_sq_ff);  opnd_b = OW'(sq_ff);     end
         ipf_pkg::MUL_INC:  begin
            opnd_a = OW'(sum_sat);
            opnd_b = $signed({{(OW-ipf_pkg::PERIOD_W){1'b0}}, per_eff[ipf_pkg::PERIOD_W-1:0]});
         end
         default:           begin opnd_a = '0; opnd_b = '0; end
      endcase
      term = ipf_pkg::TERM_W'(prod_ff >>> ipf_pkg::FRAC_BITS);
      drv_sum = (ipf_pkg::INC_W+1)'(last_drive_ff) + (ipf_pkg::INC_W+1)'(inc_ff);
      if (drv_sum < (ipf_pkg::INC_W+1)'(drive_min_ff)) begin
         drv = drive_min_ff;
      end else begin
         drv = drv_sum[W-1:0];
      end
      if (drv_sum > (ipf_pkg::INC_W+1)'(drive_max_ff) || drive_min_ff > drive_max_ff) begin
         drv = drive_max_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         meas_ff  <= req_measured;
         targ_ff  <= req_target;
         mrate_ff <= req_measured_rate;
         trate_ff <= req_target_rate;
         tacc_ff  <= req_target_accel;
         per_ff   <= req_period;
      end
      if (cmd.prep) begin
         err_ff  <= ipf_pkg::sat32(ipf_pkg::SAT_W'(err_raw));
         rerr_ff <= ipf_pkg::sat32(ipf_pkg::SAT_W'((W+1)'(mrate_ff) - (W+1)'(trate_ff)));
         qv_ff   <= '0;
         qr_ff   <= '0;
         qa_ff   <= '0;
         acc_ff  <= '0;
      end
      if (div_done) begin
         case (cmd.div_sel)
            ipf_pkg::DIV_WRAP:  err_ff <= wrap_err[W-1:0];
            ipf_pkg::DIV_ERR:   qe_ff  <= quo_sat;
            ipf_pkg::DIV_RATE:  qv_ff  <= quo_sat;
            ipf_pkg::DIV_RERR:  qr_ff  <= quo_sat;
            ipf_pkg::DIV_ACCEL: qa_ff  <= quo_sat;
            default: ;
         endcase
      end
      prod_ff <= opnd_a * opnd_b;
      case (wb_ff)
         ipf_pkg::MUL_SQ:   sq_ff  <= ipf_pkg::sat32(ipf_pkg::SAT_W'(term));
         ipf_pkg::MUL_I,
         ipf_pkg::MUL_P,
         ipf_pkg::MUL_D:    acc_ff <= acc_ff - ipf_pkg::ACC_W'(term);
         ipf_pkg::MUL_ACC,
         ipf_pkg::MUL_LIN,
         ipf_pkg::MUL_FFSQ: acc_ff <= acc_ff + ipf_pkg::ACC_W'(term);
         ipf_pkg::MUL_INC:  inc_ff <= ipf_pkg::INC_W'(term);
         default: ;
      endcase
      if (cmd.finish) begin
         rsp_drive_ff <= drv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wb_ff              <= ipf_pkg::MUL_NONE;
         rsp_valid_ff       <= 1'b0;
         first_ff           <= 1'b1;
         last_error_ff      <= '0;
         last_rate_ff       <= '0;
         last_rate_error_ff <= '0;
         last_accel_ff      <= '0;
         last_drive_ff      <= '0;
      end else begin
         wb_ff <= cmd.mul_op;
         if (cmd.finish) begin
            rsp_valid_ff       <= 1'b1;
            first_ff           <= 1'b0;
            last_error_ff      <= err_ff;
            last_rate_ff       <= mrate_ff;
            last_rate_error_ff <= rerr_ff;
            last_accel_ff      <= tacc_ff;
            last_drive_ff      <= drv;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.div_done = div_done;
   assign sts.first    = first_ff;
   assign sts.out_busy = rsp_valid_ff && !rsp_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_drive    = rsp_drive_ff;

endmodule

// File: src/ipf_ctrl.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ipf_ctrl
// Sequencer: request intake, division schedule, multiply schedule, result.
// ---------------------------------------------------------------------------
module ipf_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ipf_pkg::sts_type sts,
   output ipf_pkg::cmd_type cmd
);
   typedef enum logic [2:0] {
      ST_IDLE, ST_PREP, ST_DIV_GO, ST_DIV_WAIT, ST_MUL, ST_DONE
   } state_type;

   localparam logic [3:0] LAST_STEP = 4'd9;

   state_type            state_ff;
   ipf_pkg::div_sel_type sel_ff;
   logic [3:0]           step_ff;

   function automatic ipf_pkg::mul_op_type step_op(input logic [3:0] step);
      case (step)
         4'd0:    return ipf_pkg::MUL_SQ;
         4'd1:    return ipf_pkg::MUL_I;
         4'd2:    return ipf_pkg::MUL_P;
         4'd3:    return ipf_pkg::MUL_D;
         4'd4:    return ipf_pkg::MUL_ACC;
         4'd5:    return ipf_pkg::MUL_LIN;
         4'd6:    return ipf_pkg::MUL_FFSQ;
         4'd8:    return ipf_pkg::MUL_INC;
         default: return ipf_pkg::MUL_NONE;
      endcase
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= ipf_pkg::DIV_ERR;
         step_ff  <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_PREP;
               end
            end
            ST_PREP: begin
               state_ff <= ST_DIV_GO;
               sel_ff   <= ipf_pkg::WRAP_ANGLE ? ipf_pkg::DIV_WRAP : ipf_pkg::DIV_ERR;
            end
            ST_DIV_GO: state_ff <= ST_DIV_WAIT;
            ST_DIV_WAIT: begin
               if (sts.div_done) begin
                  state_ff <= ST_DIV_GO;
                  case (sel_ff)
                     ipf_pkg::DIV_WRAP: sel_ff <= ipf_pkg::DIV_ERR;
                     ipf_pkg::DIV_ERR: begin
                        if (sts.first) begin
                           state_ff <= ST_MUL;
                           step_ff  <= '0;
                        end else begin
                           sel_ff <= ipf_pkg::DIV_RATE;
                        end
                     end
                     ipf_pkg::DIV_RATE: sel_ff <= ipf_pkg::DIV_RERR;
                     ipf_pkg::DIV_RERR: sel_ff <= ipf_pkg::DIV_ACCEL;
                     default: begin
                        state_ff <= ST_MUL;
                        step_ff  <= '0;
                     end
                  endcase
               end
            end
            ST_MUL: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == LAST_STEP) begin
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!sts.out_busy) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign cmd.load      = (state_ff == ST_IDLE) && req_valid;
   assign cmd.prep      = (state_ff == ST_PREP);
   assign cmd.div_start = (state_ff == ST_DIV_GO);
   assign cmd.div_sel   = sel_ff;
   assign cmd.mul_op    = (state_ff == ST_MUL) ? step_op(step_ff) : ipf_pkg::MUL_NONE;
   assign cmd.finish    = (state_ff == ST_DONE) && !sts.out_busy;

   a_finish_free: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !sts.out_busy)
      else $error("result loaded while previous result pending");
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      sts.div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divider finished outside wait state");
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> step_ff <= LAST_STEP)
      else $error("multiply step out of range");
   a_load_prep: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> state_ff == ST_PREP)
      else $error("accepted request not prepared");

endmodule

// File: src/incremental_pid_with_feedforward_core.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// incremental_pid_with_feedforward_core
// Velocity-form PID step with feedforward and clamped drive, Q16.16.
// ---------------------------------------------------------------------------
// One request at a time. A request takes a prepare state, then a series of
// divisions on one shared restoring divider (one quotient bit a cycle; the
// angle wrap divides by 2*pi, the rest by the period): one on the first
// request after reset, four after that (plus one more when angle wrapping is
// built in), then a multiply sequence on the shared 33x33 multiplier and a
// result load; the next request is taken once the core is idle again.
// The next request is taken while the previous result waits to be read.
module incremental_pid_with_feedforward_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [ipf_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ipf_pkg::DATA_W-1:0]          csr_wdata,
   ipf_req_if.sink                             req_bus,
   ipf_rsp_if.source                           rsp_bus
);
   ipf_pkg::cmd_type cmd;
   ipf_pkg::sts_type sts;

   ipf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ipf_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_measured      (req_bus.measured),
      .req_target        (req_bus.target),
      .req_measured_rate (req_bus.measured_rate),
      .req_target_rate   (req_bus.target_rate),
      .req_target_accel  (req_bus.target_accel),
      .req_period        (req_bus.period),
      .rsp_valid         (rsp_bus.valid),
      .rsp_ready         (rsp_bus.ready),
      .rsp_drive         (rsp_bus.drive)
   );

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives requests into the incremental PID core with random gaps and stalls,
// predicts each clamped drive from its own copy of the controller state and
// compares every response against the oldest prediction.
// ---------------------------------------------------------------------------
module testbench;

   localparam longint S32_MAX = 64'sd2147483647;
   localparam longint S32_MIN = -64'sd2147483648;
   localparam int     F       = ipf_pkg::FRAC_BITS;

   typedef struct {
      logic signed [31:0] measured;
      logic signed [31:0] target;
      logic signed [31:0] measured_rate;
      logic signed [31:0] target_rate;
      logic signed [31:0] target_accel;
      logic [23:0]        period;
   } request_type;

   class drive_scoreboard;
      longint gain[8];
      longint last_error, last_rate, last_rate_error, last_accel, last_drive;
      bit     first_step;
      logic signed [31:0] pending[$];
      int     errors;

      function new();
         foreach (gain[k]) gain[k] = 0;
         gain[ipf_pkg::CSR_DRIVE_MIN] = S32_MIN;
         gain[ipf_pkg::CSR_DRIVE_MAX] = S32_MAX;
         last_error = 0; last_rate = 0; last_rate_error = 0;
         last_accel = 0; last_drive = 0; first_step = 1;
         errors = 0;
      endfunction

      function longint clip(longint x);
         if (x > S32_MAX) return S32_MAX;
         if (x < S32_MIN) return S32_MIN;
         return x;
      endfunction

      function longint per_dt(longint d, longint p);
         return clip((d * (64'sd1 <<< F)) / p);
      endfunction

      function longint weigh(longint g, longint v);
         return (g * v) >>> F;
      endfunction

      function void set_register(ipf_pkg::csr_index_type idx, logic [31:0] v);
         gain[idx] = longint'(signed'(v));
      endfunction

      function void note_request(request_type r);
         longint p, err, rerr, qe, qv, qr, qa, sq, total, drv;
         p = r.period == 0 ? 1 : longint'(r.period);
         err = longint'(r.measured) - longint'(r.target);
         if (ipf_pkg::WRAP_ANGLE) begin
            err = (err + ipf_pkg::PI_FIX) % ipf_pkg::TWO_PI;
            if (err < 0) err += ipf_pkg::TWO_PI;
            err -= ipf_pkg::PI_FIX;
         end
         err = clip(err);
         rerr = clip(longint'(r.measured_rate) - longint'(r.target_rate));
         qe = per_dt(err - last_error, p);
         qv = 0; qr = 0; qa = 0;
         if (!first_step) begin
            qv = per_dt(longint'(r.measured_rate) - last_rate, p);
            qr = per_dt(rerr - last_rate_error, p);
            qa = per_dt(longint'(r.target_accel) - last_accel, p);
         end
         first_step = 0;
         sq = clip((qv * (qv < 0 ? -qv : qv)) >>> F);
         total = -weigh(gain[ipf_pkg::CSR_GAIN_I], err) - weigh(gain[ipf_pkg::CSR_GAIN_P], qe)
                 - weigh(gain[ipf_pkg::CSR_GAIN_D], qr)
                 + weigh(gain[ipf_pkg::CSR_GAIN_FF_ACC], qa)
                 + weigh(gain[ipf_pkg::CSR_GAIN_FF_LIN], qv)
                 + weigh(gain[ipf_pkg::CSR_GAIN_FF_SQ], sq);
         total = clip(total);
         drv = last_drive + ((total * p) >>> F);
         if (drv < gain[ipf_pkg::CSR_DRIVE_MIN]) drv = gain[ipf_pkg::CSR_DRIVE_MIN];
         if (drv > gain[ipf_pkg::CSR_DRIVE_MAX]) drv = gain[ipf_pkg::CSR_DRIVE_MAX];
         drv = clip(drv);
         last_error = err; last_rate = r.measured_rate;
         last_rate_error = rerr; last_accel = r.target_accel; last_drive = drv;
         pending.push_back(drv[31:0]);
      endfunction

      function void check_drive(logic signed [31:0] got);
         logic signed [31:0] want;
         if (pending.size() == 0) begin
            report("drive response with no request outstanding", got, 0);
            return;
         end
         want = pending.pop_front();
         if (got !== want) report("drive mismatch", got, want);
      endfunction

      function void report(string what, logic [31:0] got, logic [31:0] want);
         $display("%s: got %h expected %h", what, got, want);
         errors++;
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;
   bit          calm = 0;
   longint      cycle = 0;

   ipf_req_if req_bus ();
   ipf_rsp_if rsp_bus ();

   incremental_pid_with_feedforward_core i_dut (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source)
   );

   drive_scoreboard board = new();

   always #5 clock = ~clock;

   initial begin
      req_bus.valid = 0; req_bus.measured = 0; req_bus.target = 0;
      req_bus.measured_rate = 0; req_bus.target_rate = 0;
      req_bus.target_accel = 0; req_bus.period = 1;
      rsp_bus.ready = 0;
   end

   always @(posedge clock) begin
      cycle <= cycle + 1;
      if (cycle > 64'd2500000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) board.check_drive(rsp_bus.drive);
      rsp_bus.ready <= calm || ($urandom_range(99) >= 34);
   end

   task automatic write_csr(ipf_pkg::csr_index_type idx, logic [31:0] v);
      csr_we <= 1; csr_index <= idx; csr_wdata <= v;
      @(posedge clock);
      csr_we <= 0;
      board.set_register(idx, v);
      @(posedge clock);
   endtask

   task automatic send_request(request_type r);
      while (!calm && $urandom_range(99) < 34) @(posedge clock);
      req_bus.valid <= 1; req_bus.measured <= r.measured; req_bus.target <= r.target;
      req_bus.measured_rate <= r.measured_rate; req_bus.target_rate <= r.target_rate;
      req_bus.target_accel <= r.target_accel; req_bus.period <= r.period;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(r);
      req_bus.valid <= 0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [31:0] pick32();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(255) - 128;
         3: return ($urandom_range(65535) - 32768) <<< 8;
         default: return $urandom;
      endcase
   endfunction

   function automatic request_type random_request(bit wild);
      request_type r;
      r.measured = wild ? pick32() : $urandom_range(2000000) - 1000000;
      r.target = wild ? pick32() : $urandom_range(2000000) - 1000000;
      r.measured_rate = wild ? pick32() : $urandom_range(400000) - 200000;
      r.target_rate = wild ? pick32() : $urandom_range(400000) - 200000;
      r.target_accel = wild ? pick32() : $urandom_range(400000) - 200000;
      case ($urandom_range(4))
         0: r.period = $urandom;
         1: r.period = $urandom_range(3);
         2: r.period = 24'hffffff;
         default: r.period = $urandom_range(6553, 655);
      endcase
      return r;
   endfunction

   task automatic random_gains(bit wild);
      for (int k = 0; k < 6; k++)
         write_csr(ipf_pkg::csr_index_type'(k),
                   wild ? pick32() : $urandom_range(131072) - 65536);
      if ($urandom_range(3) == 0) begin
         write_csr(ipf_pkg::CSR_DRIVE_MIN, pick32());
         write_csr(ipf_pkg::CSR_DRIVE_MAX, pick32());
      end else begin
         write_csr(ipf_pkg::CSR_DRIVE_MIN, -($urandom_range(1 << 24)));
         write_csr(ipf_pkg::CSR_DRIVE_MAX, $urandom_range(1 << 24));
      end
   endtask

   initial begin
      request_type r;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // first request with reset gains, then extremes
      r = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 0, 0};
      send_request(r);
      drain();
      write_csr(ipf_pkg::CSR_GAIN_P, 32'h0001_0000);
      write_csr(ipf_pkg::CSR_GAIN_I, 32'h0000_8000);
      write_csr(ipf_pkg::CSR_GAIN_D, 32'hffff_0000);
      write_csr(ipf_pkg::CSR_GAIN_FF_LIN, 32'h0002_0000);
      write_csr(ipf_pkg::CSR_GAIN_FF_SQ, 32'h0000_0100);
      write_csr(ipf_pkg::CSR_GAIN_FF_ACC, 32'h0001_0000);
      write_csr(ipf_pkg::CSR_DRIVE_MIN, 32'hff00_0000);
      write_csr(ipf_pkg::CSR_DRIVE_MAX, 32'h0100_0000);
      r = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
            32'sh7fff_ffff, 24'hffffff};
      send_request(r);
      r = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000,
            32'sh8000_0000, 24'h000001};
      send_request(r);
      for (int k = 0; k < 6; k++) send_request(random_request(1));
      drain();
      // inverted limits
      write_csr(ipf_pkg::CSR_DRIVE_MIN, 32'h0001_0000);
      write_csr(ipf_pkg::CSR_DRIVE_MAX, 32'hffff_0000);
      for (int k = 0; k < 4; k++) send_request(random_request(1));
      drain();
      write_csr(ipf_pkg::CSR_GAIN_P, 32'h8000_0000);
      write_csr(ipf_pkg::CSR_GAIN_I, 32'h7fff_ffff);
      write_csr(ipf_pkg::CSR_GAIN_D, 32'h7fff_ffff);
      write_csr(ipf_pkg::CSR_GAIN_FF_LIN, 32'h8000_0000);
      write_csr(ipf_pkg::CSR_GAIN_FF_SQ, 32'h7fff_ffff);
      write_csr(ipf_pkg::CSR_GAIN_FF_ACC, 32'h8000_0000);
      write_csr(ipf_pkg::CSR_DRIVE_MIN, 32'h8000_0000);
      write_csr(ipf_pkg::CSR_DRIVE_MAX, 32'h7fff_ffff);
      for (int k = 0; k < 6; k++) send_request(random_request(1));
      drain();
      for (int phase = 0; phase < 27; phase++) begin
         random_gains(phase % 4 == 0);
         calm = (phase == 5);
         for (int k = 0; k < 50; k++) send_request(random_request($urandom_range(4) == 0));
         if (phase % 3 == 0) begin
            drain();
         end else begin
            while (board.pending.size() != 0) @(posedge clock);
            repeat (260) @(posedge clock);
         end
      end
      calm = 0;
      drain();
      repeat (260) @(posedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
